@@ design/rdsc_pkg.sv @@
// Package for the radix digit string converter: widths, codes, the job record
// passed from the front part to the back part, and the alphabet lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rdsc_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int MAX_RADIX   = 16;
    localparam int MAX_DIGITS  = 64;

    localparam int IN_W       = 64;
    localparam int RADIX_W    = 5;
    localparam int ALPHA_W    = 64;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // The divider consumes this many dividend bits per cycle.
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int QUOT_W    = DIV_STEPS * DIV_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam int ADDR_W = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_RADIX    = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_ALPHA_LO = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_ALPHA_HI = t_cfg_idx'(2);

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [RADIX_W-1:0]     radix;
        logic                   err;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_READ,
        BK_EMIT
    } t_back_state;

    // Character for one digit; digits 0 to 7 come from the low word.
    function automatic logic [CHAR_W-1:0] alpha_char(
        input logic [ALPHA_W-1:0] lo,
        input logic [ALPHA_W-1:0] hi,
        input logic [DIGIT_W-1:0] d
    );
        logic [2*ALPHA_W-1:0] tab;
        tab = {hi, lo};
        return tab[d*CHAR_W +: CHAR_W];
    endfunction

endpackage

`default_nettype wire

@@ design/rdsc_in_if.sv @@
// Input channel of the converter: valid/ready handshake and the value.
// Depends on rdsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rdsc_in_if;
    import rdsc_pkg::*;

    logic            valid;
    logic            ready;
    logic [IN_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

@@ design/rdsc_out_if.sv @@
// Result channel of the converter: valid/ready handshake and one digit result.
// Depends on rdsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rdsc_out_if;
    import rdsc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
    logic              error_flag;

    modport source (output valid, output digit_char, output last_digit, output error_flag,
                    input ready);
    modport sink   (input valid, input digit_char, input last_digit, input error_flag,
                    output ready);
endinterface

`default_nettype wire

@@ design/radix_digit_string_converter_core.sv @@
// Flow: an accepted value is registered in the job queue; the back part then
// divides it once per digit (eight dividend bits per cycle) and emits each digit
// through a registered store read and then the output register, which holds while
// the output is not ready. A conversion gives N digits, N from 1 to 64. An error
// result goes from the queue straight into the output register. Throughput: one
// conversion at a time; the two-entry queue takes up to two more.
// Reset clears control state and the registers; the digit store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module radix_digit_string_converter_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rdsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rdsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rdsc_in_if.sink                              i_in,
    rdsc_out_if.source                           o_out
);
    import rdsc_pkg::*;

    logic [RADIX_W-1:0] r_radix;
    logic [ALPHA_W-1:0] r_alpha_lo;
    logic [ALPHA_W-1:0] r_alpha_hi;

    logic push_valid;
    t_job push_job;
    logic push_ready;
    logic pop_valid;
    t_job pop_job;
    logic pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= RADIX_RESET;
            r_alpha_lo <= '0;
            r_alpha_hi <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RADIX:    r_radix    <= i_cfg_data[RADIX_W-1:0];
                CFG_ALPHA_LO: r_alpha_lo <= i_cfg_data[ALPHA_W-1:0];
                CFG_ALPHA_HI: r_alpha_hi <= i_cfg_data[ALPHA_W-1:0];
                default: begin
                    r_radix <= r_radix;
                end
            endcase
        end
    end

    rdsc_front u_front (
        .i_in         (i_in),
        .i_radix      (r_radix),
        .i_alpha_lo   (r_alpha_lo),
        .i_alpha_hi   (r_alpha_hi),
        .o_push_valid (push_valid),
        .o_push_job   (push_job),
        .i_push_ready (push_ready)
    );

    rdsc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_job   (push_job),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_job    (pop_job),
        .i_pop_ready  (pop_ready)
    );

    rdsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_job   (pop_job),
        .o_pop_ready (pop_ready),
        .i_alpha_lo  (r_alpha_lo),
        .i_alpha_hi  (r_alpha_hi),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

@@ design/rdsc_front.sv @@
// Front part: accepts values and classifies them against the current radix and
// alphabet, producing jobs for the queue. Depends on rdsc_pkg and rdsc_in_if.
`timescale 1ns / 1ps
`default_nettype none

module rdsc_front (
    rdsc_in_if.sink                    i_in,
    input  wire logic [rdsc_pkg::RADIX_W-1:0] i_radix,
    input  wire logic [rdsc_pkg::ALPHA_W-1:0] i_alpha_lo,
    input  wire logic [rdsc_pkg::ALPHA_W-1:0] i_alpha_hi,
    output      logic                  o_push_valid,
    output      rdsc_pkg::t_job        o_push_job,
    input  wire logic                  i_push_ready
);
    import rdsc_pkg::*;

    logic bad;

    // A radix out of range, or a NUL character among the digits in use, makes
    // the whole transaction a single error result.
    always_comb begin
        bad = (i_radix < RADIX_W'(2)) || (i_radix > RADIX_W'(MAX_RADIX));
        for (int d = 0; d < MAX_RADIX; d++) begin
            if ((RADIX_W'(d) < i_radix) &&
                (alpha_char(i_alpha_lo, i_alpha_hi, DIGIT_W'(d)) == '0)) begin
                bad = 1'b1;
            end
        end
    end

    assign o_push_valid     = i_in.valid;
    assign o_push_job.value = i_in.value[VALUE_WIDTH-1:0];
    assign o_push_job.radix = i_radix;
    assign o_push_job.err   = bad;
    assign i_in.ready       = i_push_ready;

endmodule

`default_nettype wire

@@ design/rdsc_queue.sv @@
// Short job queue between the front and back parts of the converter.
// Depends on rdsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdsc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    input  wire rdsc_pkg::t_job i_push_job,
    output      logic           o_push_ready,
    output      logic           o_pop_valid,
    output      rdsc_pkg::t_job o_pop_job,
    input  wire logic           i_pop_ready
);
    import rdsc_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

endmodule

`default_nettype wire

@@ design/rdsc_back.sv @@
// Back part: divides each job by its radix one byte of quotient per cycle,
// stores the remainders, then emits them in reverse through the alphabet.
// Depends on rdsc_pkg and rdsc_out_if.
`timescale 1ns / 1ps
`default_nettype none

module rdsc_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_pop_valid,
    input  wire rdsc_pkg::t_job               i_pop_job,
    output      logic                         o_pop_ready,
    input  wire logic [rdsc_pkg::ALPHA_W-1:0] i_alpha_lo,
    input  wire logic [rdsc_pkg::ALPHA_W-1:0] i_alpha_hi,
    rdsc_out_if.source                        o_out
);
    import rdsc_pkg::*;

    t_back_state        r_state;
    t_back_state        n_state;

    logic [QUOT_W-1:0]  r_quot;
    logic [RADIX_W-1:0] r_rem;
    logic [RADIX_W-1:0] r_radix;
    logic               r_nz;
    logic [STEP_W-1:0]  r_step;
    logic [CNT_W-1:0]   r_cnt;
    logic [ADDR_W-1:0]  r_idx;

    logic [DIGIT_W-1:0] r_store [MAX_DIGITS];
    logic [DIGIT_W-1:0] r_rd_data;

    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic               r_err;

    logic [RADIX_W-1:0]  step_rem;
    logic [RADIX_W-1:0]  trial;
    logic [DIV_BITS-1:0] step_q;
    logic                last_step;
    logic                more;
    logic                out_free;
    logic                start;
    logic                out_load;
    logic                out_error;

    // Eight restoring division steps on the top byte of the working quotient.
    always_comb begin
        step_rem = r_rem;
        step_q   = '0;
        trial    = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {step_rem[RADIX_W-2:0], r_quot[QUOT_W-1-i]};
            if (trial >= r_radix) begin
                step_rem = trial - r_radix;
                step_q[DIV_BITS-1-i] = 1'b1;
            end else begin
                step_rem = trial;
            end
        end
    end

    assign last_step = (r_step == STEP_W'(DIV_STEPS - 1));
    assign more      = (r_nz || (step_q != '0)) && (r_cnt != CNT_W'(MAX_DIGITS - 1));
    assign out_free  = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_pop_valid && !i_pop_job.err) begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (last_step && !more) begin
                    n_state = BK_READ;
                end
            end
            BK_READ: begin
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (out_free) begin
                    n_state = (r_idx == '0) ? BK_IDLE : BK_READ;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop_ready = 1'b0;
        start       = 1'b0;
        out_load    = 1'b0;
        out_error   = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                o_pop_ready = !i_pop_job.err || out_free;
                start       = i_pop_valid && !i_pop_job.err;
                out_error   = i_pop_valid && i_pop_job.err && out_free;
                out_load    = out_error;
            end
            BK_EMIT: begin
                out_load = out_free;
            end
            default: begin
                o_pop_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_quot  <= QUOT_W'(i_pop_job.value);
            r_radix <= i_pop_job.radix;
            r_rem   <= '0;
            r_nz    <= 1'b0;
            r_step  <= '0;
            r_cnt   <= '0;
        end else if (r_state == BK_DIV) begin
            r_quot <= (r_quot << DIV_BITS) | QUOT_W'(step_q);
            if (last_step) begin
                r_rem  <= '0;
                r_nz   <= 1'b0;
                r_step <= '0;
                if (more) begin
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_idx <= r_cnt[ADDR_W-1:0];
                end
            end else begin
                r_rem  <= step_rem;
                r_nz   <= r_nz || (step_q != '0);
                r_step <= r_step + 1'b1;
            end
        end else if (r_state == BK_EMIT && out_free && r_idx != '0) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    // Remainder store with a registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == BK_DIV && last_step) begin
            r_store[r_cnt[ADDR_W-1:0]] <= step_rem[DIGIT_W-1:0];
        end
        r_rd_data <= r_store[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (out_error) begin
                r_char <= '0;
                r_last <= 1'b1;
                r_err  <= 1'b1;
            end else begin
                r_char <= alpha_char(i_alpha_lo, i_alpha_hi, r_rd_data);
                r_last <= (r_idx == '0);
                r_err  <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.digit_char = r_char;
    assign o_out.last_digit = r_last;
    assign o_out.error_flag = r_err;

endmodule

`default_nettype wire

@@ test/radix_digit_string_converter_checker.sv @@
// Checker for the radix digit string converter: watches the register port and
// both channels, predicts the digit results and compares them in order.
// Depends on rdsc_pkg, rdsc_in_if and rdsc_out_if.
`timescale 1ns / 1ps

module radix_digit_string_converter_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rdsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rdsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rdsc_in_if                                   i_in_mon,
    rdsc_out_if                                  i_out_mon,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_checked,
    output int                                   o_error_results
);
    import rdsc_pkg::*;

    localparam int REPORT_CAP = 40;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last_digit;
        logic              error_flag;
    } t_digit_result;

    // Shadow copies of the registers and of the remainder store.
    logic [RADIX_W-1:0]     radix_q;
    logic [ALPHA_W-1:0]     glyphs_lo;
    logic [ALPHA_W-1:0]     glyphs_hi;
    logic [DIGIT_W-1:0]     remainders [MAX_DIGITS];

    t_digit_result digits_due[$];

    function automatic logic [CHAR_W-1:0] glyph_of(input logic [3:0] d);
        logic [2*ALPHA_W-1:0] glyphs;
        glyphs = {glyphs_hi, glyphs_lo};
        return glyphs[d*CHAR_W +: CHAR_W];
    endfunction

    // Divides down by the radix and queues the digits most significant first.
    // A bad radix or a NUL character among the digits in use gives one error
    // result and leaves the held state alone.
    function automatic void predict_digits(input logic [VALUE_WIDTH-1:0] value);
        logic [63:0]   quot;
        logic [63:0]   base;
        int            n;
        bit            bad;
        t_digit_result res;
        base = 64'(radix_q);
        bad  = (radix_q < 2) || (radix_q > MAX_RADIX);
        for (int d = 0; d < 16; d++) begin
            if (!bad && d < radix_q && glyph_of(4'(d)) == 8'h00) begin
                bad = 1'b1;
            end
        end
        if (bad) begin
            res.digit_char = '0;
            res.last_digit = 1'b1;
            res.error_flag = 1'b1;
            digits_due.push_back(res);
            o_error_results++;
            return;
        end
        quot = 64'(value);
        n    = 0;
        do begin
            remainders[n] = DIGIT_W'(quot % base);
            quot = quot / base;
            n++;
        end while (quot != 0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--) begin
            res.digit_char = glyph_of(4'(remainders[k]));
            res.last_digit = (k == 0);
            res.error_flag = 1'b0;
            digits_due.push_back(res);
        end
    endfunction

    task automatic flag_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
        o_fail_count++;
        if (o_fail_count <= REPORT_CAP) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_digit_result want;
        if (!i_rst_n) begin
            radix_q       = RADIX_RESET;
            glyphs_lo     = '0;
            glyphs_hi     = '0;
            digits_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIX:    radix_q   = i_cfg_data[RADIX_W-1:0];
                    CFG_ALPHA_LO: glyphs_lo = i_cfg_data[ALPHA_W-1:0];
                    CFG_ALPHA_HI: glyphs_hi = i_cfg_data[ALPHA_W-1:0];
                    default: ;
                endcase
            end
            // Results are matched before new inputs are predicted, so a stray
            // result is never paired with a transaction from the same edge.
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (digits_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_CAP) begin
                        $display("%0t: unexpected result, expected none, actual char %0h last %0b error %0b",
                                 $time, i_out_mon.digit_char, i_out_mon.last_digit,
                                 i_out_mon.error_flag);
                    end
                end else begin
                    want = digits_due.pop_front();
                    if (i_out_mon.digit_char !== want.digit_char)
                        flag_field("digit_char", want.digit_char, i_out_mon.digit_char);
                    if (i_out_mon.last_digit !== want.last_digit)
                        flag_field("last_digit", want.last_digit, i_out_mon.last_digit);
                    if (i_out_mon.error_flag !== want.error_flag)
                        flag_field("error_flag", want.error_flag, i_out_mon.error_flag);
                    o_checked++;
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                predict_digits(i_in_mon.value[VALUE_WIDTH-1:0]);
            end
        end
        o_pending = digits_due.size();
    end

endmodule

@@ test/radix_digit_string_converter_core_test.sv @@
// Testbench top for radix_digit_string_converter_core: drives registers and
// values with random idling on both channels and gives the verdict.
// Depends on rdsc_pkg, the channel interfaces and the checker module.
`timescale 1ns / 1ps

module radix_digit_string_converter_core_test;
    import rdsc_pkg::*;

    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] GLYPHS_LO   = "76543210";
    localparam logic [63:0] GLYPHS_HI   = "FEDCBA98";
    localparam int          PHASES      = 9;
    localparam int          PER_PHASE   = 18;
    localparam int          SETTLE      = 16;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rdsc_in_if  in_ch ();
    rdsc_out_if out_ch ();

    int fail_count;
    int pending;
    int checked;
    int error_results;
    int items_sent;
    int settings_used;
    bit quiet;

    radix_digit_string_converter_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    radix_digit_string_converter_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_mon        (in_ch),
        .i_out_mon       (out_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_error_results (error_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("FAIL");
        $finish;
    end

    // Result side: ready drops in random bursts, except in the quiet phase.
    initial begin
        int run_left;
        run_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (quiet) begin
                out_ch.ready <= 1'b1;
            end else if (run_left == 0) begin
                if ($urandom_range(0, 2) == 0) begin
                    out_ch.ready <= 1'b0;
                    run_left = $urandom_range(0, 7);
                end else begin
                    out_ch.ready <= 1'b1;
                    run_left = $urandom_range(1, 24);
                end
            end else begin
                run_left--;
            end
        end
    end

    // Writes all three registers on consecutive edges; the block must be idle.
    task automatic apply_settings(input logic [RADIX_W-1:0] radix,
                                  input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_RADIX;
        i_cfg_data <= {junk[63:RADIX_W], radix};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ALPHA_LO;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ALPHA_HI;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_used++;
    endtask

    task automatic push_value(input logic [63:0] v);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Holds the sender off until every predicted result has come out.
    task automatic wait_idle(input int settle);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic logic [127:0] random_glyphs();
        logic [127:0] g;
        int           hole;
        for (int i = 0; i < 16; i++) begin
            g[i*8 +: 8] = 8'($urandom_range(1, 255));
        end
        if ($urandom_range(0, 5) == 0) begin
            hole = $urandom_range(0, 15);
            g[hole*8 +: 8] = 8'h00;
        end
        return g;
    endfunction

    // Mostly shortened values, so that digit counts spread over the range.
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = ALL_ONES;
            default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        return v;
    endfunction

    initial begin
        logic [127:0]       glyphs;
        logic [RADIX_W-1:0] radix;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_RADIX;
        i_cfg_data  <= '0;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        quiet = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset the alphabet is all NUL, so any value is an error.
        push_value(64'd12345);
        wait_idle(SETTLE);

        apply_settings(5'd10, GLYPHS_LO, GLYPHS_HI);
        push_value(64'd0);
        push_value(64'd1);
        push_value(64'd9);
        push_value(64'd10);
        push_value(ALL_ONES);
        push_value(64'd1_000_000);
        wait_idle(SETTLE);

        // Binary gives the longest digit strings.
        apply_settings(5'd2, GLYPHS_LO, GLYPHS_HI);
        push_value(64'd0);
        push_value(ALL_ONES);
        push_value(64'h8000_0000_0000_0000);
        push_value(64'd1);
        wait_idle(SETTLE);

        apply_settings(5'd16, GLYPHS_LO, GLYPHS_HI);
        push_value(ALL_ONES);
        push_value(64'h0123_4567_89AB_CDEF);
        push_value(64'd16);
        wait_idle(SETTLE);

        // Radix below two and above the maximum both give an error result.
        apply_settings(5'd0, GLYPHS_LO, GLYPHS_HI);
        push_value(64'd5);
        wait_idle(SETTLE);
        apply_settings(5'd1, GLYPHS_LO, GLYPHS_HI);
        push_value(64'd5);
        wait_idle(SETTLE);
        apply_settings(5'd17, GLYPHS_LO, GLYPHS_HI);
        push_value(64'd5);
        wait_idle(SETTLE);
        apply_settings(5'd31, GLYPHS_LO, GLYPHS_HI);
        push_value(64'd5);
        wait_idle(SETTLE);

        // A NUL character only matters when its digit is in use.
        apply_settings(5'd3, GLYPHS_LO & ~64'h0000_0000_00FF_0000, GLYPHS_HI);
        push_value(64'd7);
        wait_idle(SETTLE);
        apply_settings(5'd15, GLYPHS_LO, GLYPHS_HI & 64'h00FF_FFFF_FFFF_FFFF);
        push_value(ALL_ONES);
        wait_idle(SETTLE);
        apply_settings(5'd16, GLYPHS_LO, GLYPHS_HI & 64'h00FF_FFFF_FFFF_FFFF);
        push_value(ALL_ONES);
        wait_idle(SETTLE);

        apply_settings(5'd7, ALL_ONES, ALL_ONES);
        push_value({$urandom, $urandom});
        wait_idle(SETTLE);

        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES - 1) begin
                quiet = 1'b1;
                radix = 5'd16;
                glyphs = {GLYPHS_HI, GLYPHS_LO};
            end else begin
                radix = ($urandom_range(0, 11) == 0) ? RADIX_W'($urandom_range(0, 31))
                                                     : RADIX_W'($urandom_range(2, 16));
                glyphs = random_glyphs();
            end
            apply_settings(radix, glyphs[63:0], glyphs[127:64]);
            for (int i = 0; i < PER_PHASE; i++) begin
                push_value(random_value());
            end
            wait_idle(SETTLE);
        end

        wait_idle(4 * SETTLE);
        $display("Converted %0d values under %0d register settings.", items_sent, settings_used);
        $display("Compared %0d digit results, %0d of them error results.", checked,
                 error_results);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
